// ===== hw/rtl/aprt_pkg.sv =====
// ----------------------------------------------------------------------------
// aprt_pkg: shared definitions for the affine point/rectangle transform
// Request kinds, register indexes, default widths and pipeline enables.
// ----------------------------------------------------------------------------
package aprt_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // request kinds carried in tuser
   localparam int OP_WIDTH = 2;
   localparam logic [OP_WIDTH-1:0] OP_POINT  = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_VECTOR = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_RECT   = 2'd2;

   // configuration register indexes
   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_XX  = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_XY  = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_YX  = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_YY  = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_OFFSET_X = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_OFFSET_Y = 3'd5;

   // number of register stages from request to response
   localparam int PIPE_DEPTH = 6;

   // load enables of the stages held inside each axis lane
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

// ===== hw/rtl/aprt_lane.sv =====
// ----------------------------------------------------------------------------
// aprt_lane: one output axis of the affine transform
// Forms c1*p + c2*q (+ offset) for the four rectangle corners, rounds and
// saturates each corner, then reduces them to a minimum and a maximum.
// ----------------------------------------------------------------------------
module aprt_lane #(
   parameter int COORD_WIDTH = aprt_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = aprt_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  aprt_pkg::stage_en_type        en,
   input  logic signed [COORD_WIDTH-1:0] c1,
   input  logic signed [COORD_WIDTH-1:0] c2,
   input  logic signed [COORD_WIDTH-1:0] off,
   input  logic                          use_off,
   input  logic signed [COORD_WIDTH:0]   p0,
   input  logic signed [COORD_WIDTH:0]   p1,
   input  logic signed [COORD_WIDTH:0]   q0,
   input  logic signed [COORD_WIDTH:0]   q1,
   output logic signed [COORD_WIDTH-1:0] pt_out,
   output logic signed [COORD_WIDTH-1:0] min_out,
   output logic signed [COORD_WIDTH-1:0] max_out,
   output logic                          pt_clip,
   output logic                          any_clip
);
   import aprt_pkg::*;

   localparam int W      = COORD_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int PROD_W = 2 * W + 1;
   localparam int SUM_W  = 2 * W + 3;
   localparam int HI_W   = SUM_W - W - F + 1;
   localparam logic signed [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};

   // stage 2: products c1*p0, c1*p1, c2*q0, c2*q1 and the offset term
   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [SUM_W-1:0]  ofs_ff;
   logic signed [SUM_W-1:0]  ofs_in;

   // offset shifted up with the rounding half already in its zero bits
   assign ofs_in = use_off ? {{(SUM_W-W-F){off[W-1]}}, off, 1'b1, {(F-1){1'b0}}}
                           : SUM_W'({1'b1, {(F-1){1'b0}}});

   always_ff @(posedge clock) begin
      if (en.s2) begin
         prod_ff[0] <= c1 * p0;
         prod_ff[1] <= c1 * p1;
         prod_ff[2] <= c2 * q0;
         prod_ff[3] <= c2 * q1;
         ofs_ff     <= ofs_in;
      end
   end

   // stage 3: corner sums; stage 4: round and saturate each corner
   logic signed [SUM_W-1:0] sum_ff [4];
   logic signed [W-1:0]     cor_ff [4];
   logic                    clip_ff [4];

   for (genvar k = 0; k < 4; k++) begin : g_corner
      localparam int PI = k % 2;
      localparam int QI = 2 + k / 2;
      logic signed [SUM_W-1:0] sum_in;
      logic [HI_W-1:0]         hi_bits;
      logic                    ovf;
      logic signed [W-1:0]     cor_in;

      assign sum_in = {{(SUM_W-PROD_W){prod_ff[PI][PROD_W-1]}}, prod_ff[PI]}
                    + {{(SUM_W-PROD_W){prod_ff[QI][PROD_W-1]}}, prod_ff[QI]}
                    + ofs_ff;

      assign hi_bits = sum_ff[k][SUM_W-1:W-1+F];
      assign ovf     = !((&hi_bits) || !(|hi_bits));
      assign cor_in  = ovf ? (hi_bits[HI_W-1] ? MAX_NEG : MAX_POS)
                           : sum_ff[k][W-1+F:F];

      always_ff @(posedge clock) begin
         if (en.s3) begin
            sum_ff[k] <= sum_in;
         end
         if (en.s4) begin
            cor_ff[k]  <= cor_in;
            clip_ff[k] <= ovf;
         end
      end
   end

   // stage 5: min and max over the four corners
   logic signed [W-1:0] lo01, lo23, hi01, hi23;
   logic signed [W-1:0] min_in, max_in;
   logic signed [W-1:0] pt_ff, min_ff, max_ff;
   logic                pt_clip_ff, any_clip_ff;

   always_comb begin
      lo01   = (cor_ff[1] < cor_ff[0]) ? cor_ff[1] : cor_ff[0];
      lo23   = (cor_ff[3] < cor_ff[2]) ? cor_ff[3] : cor_ff[2];
      hi01   = (cor_ff[1] > cor_ff[0]) ? cor_ff[1] : cor_ff[0];
      hi23   = (cor_ff[3] > cor_ff[2]) ? cor_ff[3] : cor_ff[2];
      min_in = (lo23 < lo01) ? lo23 : lo01;
      max_in = (hi23 > hi01) ? hi23 : hi01;
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         pt_ff       <= cor_ff[0];
         min_ff      <= min_in;
         max_ff      <= max_in;
         pt_clip_ff  <= clip_ff[0];
         any_clip_ff <= clip_ff[0] | clip_ff[1] | clip_ff[2] | clip_ff[3];
      end
   end

   assign pt_out   = pt_ff;
   assign min_out  = min_ff;
   assign max_out  = max_ff;
   assign pt_clip  = pt_clip_ff;
   assign any_clip = any_clip_ff;

endmodule

// ===== hw/rtl/affine_point_rect_transform.sv =====
// ----------------------------------------------------------------------------
// affine_point_rect_transform: 2D affine transform with bounding-box mode
// Transforms points, vectors and rectangles by a programmable Q16.16 matrix.
// ----------------------------------------------------------------------------
// Takes one request per clock unless a response stall has filled every stage,
// and returns one response per request, in order. An accepted request passes
// through the register stages in order; rsp_tvalid is raised while it sits in the last.
// The six register stages are: request capture with the far rectangle edges,
// the eight coefficient products (four per axis, each for two corners), corner
// sums, rounding with saturation, corner min/max, and the box size with the
// response register. Each stage holds its own valid bit, so the request side
// keeps accepting while a response waits, until every stage is full.
// The user must write registers through csr_wen/csr_addr/csr_wdata while idle;
// the block does not enforce it. A write to an index beyond offset_y is ignored.
module affine_point_rect_transform #(
   parameter int COORD_WIDTH = aprt_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = aprt_pkg::FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // in_x, in_y, in_w, in_h
   input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]        req_tdata,
   // op
   input  logic [aprt_pkg::OP_WIDTH-1:0]             req_tuser,
   // response
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // out_x, out_y, out_w, out_h
   output logic [((4*COORD_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   // saturated
   output logic                                      rsp_tuser,
   // configuration
   input  logic                                      csr_wen,
   input  logic [aprt_pkg::CSR_ADDR_WIDTH-1:0]       csr_addr,
   input  logic [COORD_WIDTH-1:0]                    csr_wdata
);
   import aprt_pkg::*;

   localparam int W       = COORD_WIDTH;
   localparam int TDATA_W = ((4 * W + 7) / 8) * 8;
   localparam logic [W-1:0] ONE     = W'(1) << FRAC_BITS;
   localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

   // ---------------- configuration registers ----------------
   logic signed [W-1:0] cxx_ff, cxy_ff, cyx_ff, cyy_ff, offx_ff, offy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cxx_ff  <= ONE;
         cxy_ff  <= '0;
         cyx_ff  <= '0;
         cyy_ff  <= ONE;
         offx_ff <= '0;
         offy_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_COEF_XX:  cxx_ff  <= csr_wdata;
            REG_COEF_XY:  cxy_ff  <= csr_wdata;
            REG_COEF_YX:  cyx_ff  <= csr_wdata;
            REG_COEF_YY:  cyy_ff  <= csr_wdata;
            REG_OFFSET_X: offx_ff <= csr_wdata;
            REG_OFFSET_Y: offy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage handshake ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in, v6_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
   stage_en_type lane_en;

   // a stage loads when it is empty or its contents move on
   assign rdy6 = !v6_ff || rsp_tready;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign v1_in = rdy1 ? req_tvalid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;
   assign v5_in = rdy5 ? v4_ff : v5_ff;
   assign v6_in = rdy6 ? v5_ff : v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   assign lane_en.s2 = rdy2;
   assign lane_en.s3 = rdy3;
   assign lane_en.s4 = rdy4;
   assign lane_en.s5 = rdy5;

   assign req_tready = rdy1;
   assign rsp_tvalid = v6_ff;

   // ---------------- stage 1: capture, far edges ----------------
   logic signed [W-1:0] in_x, in_y, in_w, in_h;
   logic signed [W:0]   x0_ff, y0_ff, x1_ff, y1_ff;
   logic [OP_WIDTH-1:0] op1_ff, op2_ff, op3_ff, op4_ff, op5_ff;

   assign in_x = req_tdata[W-1:0];
   assign in_y = req_tdata[2*W-1:W];
   assign in_w = req_tdata[3*W-1:2*W];
   assign in_h = req_tdata[4*W-1:3*W];

   always_ff @(posedge clock) begin
      if (rdy1) begin
         op1_ff <= req_tuser;
         x0_ff  <= {in_x[W-1], in_x};
         y0_ff  <= {in_y[W-1], in_y};
         x1_ff  <= {in_x[W-1], in_x} + {in_w[W-1], in_w};
         y1_ff  <= {in_y[W-1], in_y} + {in_h[W-1], in_h};
      end
      if (rdy2) op2_ff <= op1_ff;
      if (rdy3) op3_ff <= op2_ff;
      if (rdy4) op4_ff <= op3_ff;
      if (rdy5) op5_ff <= op4_ff;
   end

   // ---------------- stages 2 to 5: one lane per axis ----------------
   logic                use_off;
   logic signed [W-1:0] ptx, mnx, mxx, pty, mny, mxy;
   logic                ptx_clip, anyx_clip, pty_clip, anyy_clip;

   assign use_off = (op1_ff != OP_VECTOR);

   aprt_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock    (clock),
      .en       (lane_en),
      .c1       (cxx_ff),
      .c2       (cyx_ff),
      .off      (offx_ff),
      .use_off  (use_off),
      .p0       (x0_ff),
      .p1       (x1_ff),
      .q0       (y0_ff),
      .q1       (y1_ff),
      .pt_out   (ptx),
      .min_out  (mnx),
      .max_out  (mxx),
      .pt_clip  (ptx_clip),
      .any_clip (anyx_clip)
   );

   aprt_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock    (clock),
      .en       (lane_en),
      .c1       (cxy_ff),
      .c2       (cyy_ff),
      .off      (offy_ff),
      .use_off  (use_off),
      .p0       (x0_ff),
      .p1       (x1_ff),
      .q0       (y0_ff),
      .q1       (y1_ff),
      .pt_out   (pty),
      .min_out  (mny),
      .max_out  (mxy),
      .pt_clip  (pty_clip),
      .any_clip (anyy_clip)
   );

   // ---------------- stage 6: box size and response ----------------
   logic [W:0]   span_x, span_y;
   logic         ovf_w, ovf_h;
   logic [W-1:0] ox_in, oy_in, ow_in, oh_in;
   logic         sat_in;
   logic [W-1:0] ox_ff, oy_ff, ow_ff, oh_ff;
   logic         sat_ff;

   assign span_x = {mxx[W-1], mxx} - {mnx[W-1], mnx};
   assign span_y = {mxy[W-1], mxy} - {mny[W-1], mny};
   // span is never negative; clip what does not fit the positive range
   assign ovf_w  = span_x[W] | span_x[W-1];
   assign ovf_h  = span_y[W] | span_y[W-1];

   always_comb begin
      unique case (op5_ff)
         OP_POINT, OP_VECTOR: begin
            ox_in  = ptx;
            oy_in  = pty;
            ow_in  = '0;
            oh_in  = '0;
            sat_in = ptx_clip | pty_clip;
         end
         OP_RECT: begin
            ox_in  = mnx;
            oy_in  = mny;
            ow_in  = ovf_w ? MAX_POS : span_x[W-1:0];
            oh_in  = ovf_h ? MAX_POS : span_y[W-1:0];
            sat_in = anyx_clip | anyy_clip | ovf_w | ovf_h;
         end
         default: begin
            ox_in  = '0;
            oy_in  = '0;
            ow_in  = '0;
            oh_in  = '0;
            sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         ow_ff  <= ow_in;
         oh_ff  <= oh_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tdata = TDATA_W'({oh_ff, ow_ff, oy_ff, ox_ff});
   assign rsp_tuser = sat_ff;

endmodule

// ===== hw/rtl/aprt_checker.sv =====
// ----------------------------------------------------------------------------
// aprt_checker: port-level checks for the affine transform
// Tracks requests in flight and checks the response side over time.
// ----------------------------------------------------------------------------
module aprt_checker #(
   parameter int COORD_WIDTH = aprt_pkg::COORD_WIDTH_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((4*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic                               rsp_tuser
);
   import aprt_pkg::*;

   localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

   logic             req_acc, rsp_acc;
   logic [CNT_W-1:0] count_ff, count_in;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_acc  = rsp_tvalid && rsp_tready;
   assign count_in = count_ff + CNT_W'(req_acc) - CNT_W'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count_ff != '0)
      else $error("response without a request in flight");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more requests in flight than stages");

   a_flow_through: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while response side is ready");

endmodule

bind affine_point_rect_transform aprt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_aprt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
